[rtl/wpfd_pkg.sv]
package wpfd_pkg;

	typedef enum logic [6:0] {
		SEC_IDLE = 7'b000_0001,
		SEC_EXT  = 7'b000_0010,
		SEC_POS  = 7'b000_0100,
		SEC_TEMP = 7'b000_1000,
		SEC_WIND = 7'b001_0000,
		SEC_HUM  = 7'b010_0000,
		SEC_PRES = 7'b100_0000
	} sec_t;

	localparam logic [2:0] KIND_POS  = 3'd0;
	localparam logic [2:0] KIND_TEMP = 3'd1;
	localparam logic [2:0] KIND_WIND = 3'd2;
	localparam logic [2:0] KIND_HUM  = 3'd3;
	localparam logic [2:0] KIND_PRES = 3'd4;

	localparam logic [7:0] FLAG_EXT  = 8'h01;
	localparam logic [7:0] FLAG_TEMP = 8'h40;
	localparam logic [7:0] FLAG_WIND = 8'h20;
	localparam logic [7:0] FLAG_HUM  = 8'h10;
	localparam logic [7:0] FLAG_PRES = 8'h08;

	localparam logic [9:0] HUM_MAX = 10'd1000;

	typedef struct packed {
		logic [2:0]        kind;
		logic [47:0]       position_raw;
		logic signed [7:0] temperature_half_c;
		logic [14:0]       heading_64th_deg;
		logic [9:0]        speed_fifth_kmh;
		logic [9:0]        gust_fifth_kmh;
		logic [9:0]        humidity_tenth_pct;
		logic [16:0]       pressure_pa;
		logic              last;
	} res_t;

endpackage

[rtl/wpfd_ifs.sv]
interface wpfd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_start;

	modport source (output valid, output rx_byte, output frame_start, input ready);
	modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface wpfd_res_if;
	logic              valid;
	logic              ready;
	logic [2:0]        kind;
	logic [47:0]       position_raw;
	logic signed [7:0] temperature_half_c;
	logic [14:0]       heading_64th_deg;
	logic [9:0]        speed_fifth_kmh;
	logic [9:0]        gust_fifth_kmh;
	logic [9:0]        humidity_tenth_pct;
	logic [16:0]       pressure_pa;
	logic              last;

	modport source (
		output valid, output kind, output position_raw, output temperature_half_c,
		output heading_64th_deg, output speed_fifth_kmh, output gust_fifth_kmh,
		output humidity_tenth_pct, output pressure_pa, output last, input ready
	);
	modport sink (
		input valid, input kind, input position_raw, input temperature_half_c,
		input heading_64th_deg, input speed_fifth_kmh, input gust_fifth_kmh,
		input humidity_tenth_pct, input pressure_pa, input last, output ready
	);
endinterface

[rtl/wpfd_field_calc.sv]
module wpfd_field_calc
	import wpfd_pkg::*;
(
	input  sec_t        sec,
	input  logic [7:0]  rx_byte,
	input  logic [47:0] gather,
	input  logic [14:0] heading_in,
	output res_t        res,
	output logic [14:0] heading_next
);

	localparam logic [20:0] HD_ROUND = 21'd25;
	localparam logic [21:0] HD_RECIP = 22'd2631721;
	localparam int          HD_SHIFT = 27;

	logic [20:0] hd_num;
	logic [42:0] hd_prod;
	logic [9:0]  hum_raw;

	function automatic logic [9:0] speed_of(input logic [7:0] b);
		logic [9:0] v;
		v = {3'b000, b[6:0]};
		return b[7] ? ((v << 2) + v) : v;
	endfunction

	// heading = round(b * 23040 / 255) = floor((b * 4608 + 25) / 51)
	assign hd_num       = 21'({rx_byte, 12'b0}) + 21'({rx_byte, 9'b0}) + HD_ROUND;
	assign hd_prod      = 43'(hd_num) * 43'(HD_RECIP);
	assign heading_next = hd_prod[HD_SHIFT +: 15];

	assign hum_raw = {rx_byte, 2'b00};

	always_comb begin
		res = '0;
		unique case (sec)
			SEC_POS: begin
				res.kind         = KIND_POS;
				res.position_raw = {rx_byte, gather[39:0]};
			end
			SEC_TEMP: begin
				res.kind               = KIND_TEMP;
				res.temperature_half_c = $signed(rx_byte);
			end
			SEC_WIND: begin
				res.kind             = KIND_WIND;
				res.heading_64th_deg = heading_in;
				res.speed_fifth_kmh  = speed_of(gather[15:8]);
				res.gust_fifth_kmh   = speed_of(rx_byte);
			end
			SEC_HUM: begin
				res.kind               = KIND_HUM;
				res.humidity_tenth_pct = (hum_raw > HUM_MAX) ? HUM_MAX : hum_raw;
			end
			SEC_PRES: begin
				res.kind        = KIND_PRES;
				res.pressure_pa = 17'({rx_byte, gather[7:0]}) + 17'd43000;
			end
			default: begin
				res = '0;
			end
		endcase
	end

endmodule

[rtl/weather_payload_field_decoder.sv]
// Weather payload field decoder.
// rx channel: one payload word per handshake (rx_byte, frame_start). A word with
// frame_start is the header; its flags select the optional fields that follow
// an optional extended header word and six position words.
// res channel: one word per decoded field (position, temperature, wind,
// humidity, pressure), last set on the final field of the payload.
// Result path: the rx word that completes a field is registered in the input
// register, then its result is registered on res once res is free.
// Throughput: one rx word per cycle, sustained while res keeps up. Each word is
// registered, then decoded through one short stage (the heading step is one
// 21 x 22 multiply) into the result register.
// Reset: idle, nothing pending; words without frame_start are dropped until a
// header arrives. A new header aborts any payload in progress.
// Stall: while res is held off with a result waiting, the block keeps taking rx
// words that give no result; the first word that would give one holds in the
// input register and rx.ready drops until the pending result is taken.
module weather_payload_field_decoder
	import wpfd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	wpfd_rx_if.sink    rx,
	wpfd_res_if.source res
);

	localparam logic [2:0] POS_LAST_IDX  = 3'd5;
	localparam logic [2:0] WIND_LAST_IDX = 3'd2;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;

	sec_t        sec_q, sec_d, sec_next;
	logic [7:0]  flags_q, flags_d;
	logic [2:0]  idx_q, idx_d;
	logic [47:0] gather_q, gather_d;
	logic [14:0] heading_q, heading_next;

	logic        res_valid_q;
	res_t        res_q, res_d, calc_res;

	logic        produce, load_head, gather_wr, out_free, go;

	function automatic sec_t next_section(input sec_t s, input logic [7:0] f);
		logic take_temp, take_wind, take_hum, take_pres;
		take_temp = (s == SEC_POS) && ((f & FLAG_TEMP) != '0);
		take_wind = ((s == SEC_POS) || (s == SEC_TEMP)) && ((f & FLAG_WIND) != '0);
		take_hum  = ((s == SEC_POS) || (s == SEC_TEMP) || (s == SEC_WIND))
			&& ((f & FLAG_HUM) != '0);
		take_pres = ((s == SEC_POS) || (s == SEC_TEMP) || (s == SEC_WIND) || (s == SEC_HUM))
			&& ((f & FLAG_PRES) != '0);
		if (take_temp) return SEC_TEMP;
		else if (take_wind) return SEC_WIND;
		else if (take_hum) return SEC_HUM;
		else if (take_pres) return SEC_PRES;
		else return SEC_IDLE;
	endfunction

	wpfd_field_calc u_calc (
		.sec          (sec_q),
		.rx_byte      (byte_s1),
		.gather       (gather_q),
		.heading_in   (heading_q),
		.res          (calc_res),
		.heading_next (heading_next)
	);

	assign sec_next = next_section(sec_q, flags_q);

	always_comb begin
		sec_d     = sec_q;
		flags_d   = flags_q;
		idx_d     = idx_q;
		gather_d  = gather_q;
		produce   = 1'b0;
		load_head = 1'b0;
		gather_wr = 1'b0;
		if (start_s1) begin
			sec_d    = ((byte_s1 & FLAG_EXT) != '0) ? SEC_EXT : SEC_POS;
			flags_d  = byte_s1;
			idx_d    = '0;
			gather_d = '0;
		end else begin
			unique case (sec_q)
				SEC_IDLE: begin
					sec_d = SEC_IDLE;
				end
				SEC_EXT: begin
					sec_d    = SEC_POS;
					idx_d    = '0;
					gather_d = '0;
				end
				SEC_POS: begin
					if (idx_q >= POS_LAST_IDX) produce = 1'b1;
					else gather_wr = 1'b1;
				end
				SEC_TEMP: begin
					produce = 1'b1;
				end
				SEC_WIND: begin
					if (idx_q >= WIND_LAST_IDX) begin
						produce = 1'b1;
					end else begin
						gather_wr = 1'b1;
						load_head = (idx_q == '0);
					end
				end
				SEC_HUM: begin
					produce = 1'b1;
				end
				SEC_PRES: begin
					if (idx_q != '0) produce = 1'b1;
					else gather_wr = 1'b1;
				end
				default: begin
					sec_d    = SEC_IDLE;
					idx_d    = '0;
					gather_d = '0;
				end
			endcase
			if (gather_wr) begin
				for (int i = 0; i < 6; i++) begin
					if (idx_q == 3'(i)) gather_d[8*i +: 8] = byte_s1;
				end
				idx_d = idx_q + 3'd1;
			end
			if (produce) begin
				sec_d    = sec_next;
				idx_d    = '0;
				gather_d = '0;
			end
		end
	end

	always_comb begin
		res_d      = calc_res;
		res_d.last = (sec_next == SEC_IDLE);
	end

	assign out_free = !res_valid_q || res.ready;
	assign go       = valid_s1 && (!produce || out_free);
	assign rx.ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1  <= rx.rx_byte;
			start_s1 <= rx.frame_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q    <= SEC_IDLE;
			flags_q  <= '0;
			idx_q    <= '0;
			gather_q <= '0;
		end else if (go) begin
			sec_q    <= sec_d;
			flags_q  <= flags_d;
			idx_q    <= idx_d;
			gather_q <= gather_d;
		end
	end

	always_ff @(posedge clk) begin
		if (go && load_head) begin
			heading_q <= heading_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (go && produce) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && produce) begin
			res_q <= res_d;
		end
	end

	assign res.valid              = res_valid_q;
	assign res.kind               = res_q.kind;
	assign res.position_raw       = res_q.position_raw;
	assign res.temperature_half_c = res_q.temperature_half_c;
	assign res.heading_64th_deg   = res_q.heading_64th_deg;
	assign res.speed_fifth_kmh    = res_q.speed_fifth_kmh;
	assign res.gust_fifth_kmh     = res_q.gust_fifth_kmh;
	assign res.humidity_tenth_pct = res_q.humidity_tenth_pct;
	assign res.pressure_pa        = res_q.pressure_pa;
	assign res.last               = res_q.last;

endmodule

[rtl/wpfd_checker.sv]
module wpfd_checker
	import wpfd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [2:0]  kind,
	input logic [47:0] position_raw,
	input logic [14:0] heading_64th_deg,
	input logic [9:0]  speed_fifth_kmh,
	input logic [9:0]  gust_fifth_kmh,
	input logic [9:0]  humidity_tenth_pct,
	input logic [16:0] pressure_pa
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(position_raw)
			&& $stable(pressure_pa))
		else $error("result word changed while stalled");

	a_pos_only: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind != KIND_POS) |-> position_raw == '0)
		else $error("position bits set on a non-position word");

	a_wind_only: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind != KIND_WIND) |->
			heading_64th_deg == '0 && speed_fifth_kmh == '0 && gust_fifth_kmh == '0)
		else $error("wind fields set on a non-wind word");

	a_hum_sat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> humidity_tenth_pct <= HUM_MAX)
		else $error("humidity above saturation");

endmodule

bind weather_payload_field_decoder wpfd_checker u_wpfd_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.res_valid          (res.valid),
	.res_ready          (res.ready),
	.kind               (res.kind),
	.position_raw       (res.position_raw),
	.heading_64th_deg   (res.heading_64th_deg),
	.speed_fifth_kmh    (res.speed_fifth_kmh),
	.gust_fifth_kmh     (res.gust_fifth_kmh),
	.humidity_tenth_pct (res.humidity_tenth_pct),
	.pressure_pa        (res.pressure_pa)
);
